/* sv/hdrm_pkg.sv */
`default_nettype none
package hdrm_pkg;

  localparam int PIXEL_LEVELS_DEF  = 65536;
  localparam int MAX_EXPOSURES_DEF = 4;

  localparam int SAMPLE_W   = 16;
  localparam int DIFF_W     = 17;
  localparam int RATIO_W    = 17;
  localparam int P2_W       = 18;
  localparam int P_W        = 19;
  localparam int X_W        = 36;
  localparam int LIN_W      = 25;
  localparam int CODE_W     = 16;
  localparam int OFFSET_W   = 18;
  localparam int COUNT_W    = 3;
  localparam int FRAC_BITS  = 12;
  localparam int EXP_W      = 6;
  localparam int MANT_W     = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [P_W-1:0]          UNITY_RATIO = 19'd65536;
  localparam logic [RATIO_W-1:0]      RATIO_RESET = 17'd65536;
  localparam logic signed [LIN_W-1:0] LIN_MAX     = 25'sd16776960;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPOSURE_COUNT = 3'd0,
    REG_RATIO_FIRST    = 3'd1,
    REG_RATIO_SECOND   = 3'd2,
    REG_RATIO_THIRD    = 3'd3,
    REG_LOG_OFFSET     = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [SAMPLE_W-1:0] sample_c;
    logic [SAMPLE_W-1:0] sample_d;
    logic [SAMPLE_W-1:0] background;
  } pixel_t;

  typedef struct packed {
    logic signed [LIN_W-1:0] linear_intensity;
    logic [CODE_W-1:0]       log_code;
  } result_t;

  typedef struct packed {
    logic                    pos;
    logic [EXP_W-1:0]        e;
    logic signed [LIN_W-1:0] lin;
  } log_side_t;

endpackage
`default_nettype wire

/* sv/hdrm_log2.sv */
`default_nettype none
module hdrm_log2
  import hdrm_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        x_valid,
  input  wire logic signed [X_W-1:0]       x,
  input  wire logic [OFFSET_W-1:0]         log_offset,
  output logic                             result_valid,
  output result_t                          result
);

  localparam int LIN_RAW_W = X_W - 8;
  localparam logic signed [LIN_RAW_W-1:0] LIN_HI = LIN_RAW_W'(LIN_MAX);
  localparam logic signed [LIN_RAW_W-1:0] LIN_LO = -LIN_RAW_W'(LIN_MAX);
  localparam int SUM_W = 21;
  localparam logic signed [SUM_W-1:0] CODE_BIAS = 21'sd65536;
  localparam logic signed [SUM_W-1:0] CODE_TOP  = 21'sd65535;

  logic                    a_vld;
  log_side_t               a_side;
  logic [X_W-2:0]          a_mag;

  log_side_t               a_side_next;
  logic [LIN_RAW_W-1:0]    lin_raw;

  logic                    sq_vld  [0:FRAC_BITS];
  logic [MANT_W-1:0]       sq_m    [0:FRAC_BITS];
  logic [FRAC_BITS-1:0]    sq_frac [0:FRAC_BITS];
  log_side_t               sq_side [0:FRAC_BITS];

  logic [X_W+MANT_W-2:0]   norm_wide;
  logic signed [SUM_W-1:0] code_sum;
  result_t                 result_next;

  always_comb begin
    lin_raw = x[X_W-1:8];
    a_side_next.pos = !x[X_W-1] && (|x);
    if ($signed(lin_raw) > LIN_HI) begin
      a_side_next.lin = LIN_MAX;
    end else if ($signed(lin_raw) < LIN_LO) begin
      a_side_next.lin = -LIN_MAX;
    end else begin
      a_side_next.lin = LIN_W'(lin_raw);
    end
    a_side_next.e = '0;
    for (int i = 0; i < X_W - 1; i++) begin
      if (x[i]) begin
        a_side_next.e = EXP_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= x_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side <= a_side_next;
      a_mag  <= x[X_W-2:0];
    end
  end

  assign norm_wide = ({{MANT_W{1'b0}}, a_mag} << (MANT_W - 1)) >> a_side.e;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (en) begin
      sq_vld[0] <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_m[0]    <= norm_wide[MANT_W-1:0];
      sq_frac[0] <= '0;
      sq_side[0] <= a_side;
    end
  end

  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_square
    logic [2*MANT_W-1:0] sq_full;
    logic [MANT_W:0]     sq_top;
    logic                bit_one;

    assign sq_full = sq_m[j] * sq_m[j];
    assign sq_top  = sq_full[2*MANT_W-1:MANT_W-1];
    assign bit_one = sq_top[MANT_W];

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[j+1] <= 1'b0;
      end else if (en) begin
        sq_vld[j+1] <= sq_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_m[j+1]    <= bit_one ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
        sq_frac[j+1] <= {sq_frac[j][FRAC_BITS-2:0], bit_one};
        sq_side[j+1] <= sq_side[j];
      end
    end
  end

  always_comb begin
    code_sum = $signed({3'b000, sq_side[FRAC_BITS].e, sq_frac[FRAC_BITS]})
             + $signed({3'b000, log_offset}) - CODE_BIAS;
    result_next.linear_intensity = sq_side[FRAC_BITS].lin;
    if (!sq_side[FRAC_BITS].pos || code_sum < 0) begin
      result_next.log_code = '0;
    end else if (code_sum > CODE_TOP) begin
      result_next.log_code = '1;
    end else begin
      result_next.log_code = code_sum[CODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= sq_vld[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

/* sv/hdr_exposure_pixel_merge_unit.sv */
`default_nettype none
// HDR pixel merge: one pixel request enters per cycle unless stalled. Three
// front stages pick the exposure, form the ratio product and multiply it by
// the background-corrected sample; the back end finds the leading one,
// normalizes, and runs twelve squaring stages (one log2 fraction bit each)
// before the clamped code is registered. A stall on the result side holds
// every stage, and the pixel side is stalled exactly while a held result is
// waiting. Configuration is taken every cycle and must only change while no
// pixel is in flight.
module hdr_exposure_pixel_merge_unit
  import hdrm_pkg::*;
#(
  parameter int PIXEL_LEVELS  = PIXEL_LEVELS_DEF,
  parameter int MAX_EXPOSURES = MAX_EXPOSURES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pixel_valid,
  output logic                       pixel_stall,
  input  wire pixel_t                pixel,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output result_t                    result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [SAMPLE_W-1:0] SAT_LEVEL = SAMPLE_W'(PIXEL_LEVELS - 1);
  localparam logic [COUNT_W-1:0]  MAX_N     = COUNT_W'(MAX_EXPOSURES);

  logic [COUNT_W-1:0]  exposure_count;
  logic [RATIO_W-1:0]  ratio_first;
  logic [RATIO_W-1:0]  ratio_second;
  logic [RATIO_W-1:0]  ratio_third;
  logic [OFFSET_W-1:0] log_offset;

  logic en;

  logic [SAMPLE_W-1:0]      samp [0:3];
  logic [3:0]               ok;
  logic [COUNT_W-1:0]       n_eff;
  logic [1:0]               sel_next;
  logic signed [DIFF_W-1:0] diff_next;
  logic [2*RATIO_W-1:0]     prod01;

  logic                     s1_vld;
  logic signed [DIFF_W-1:0] s1_diff;
  logic [1:0]               s1_sel;
  logic [P2_W-1:0]          s1_p2;

  logic [P2_W+RATIO_W-1:0]  prod2;
  logic [P_W-1:0]           p_next;

  logic                     s2_vld;
  logic signed [DIFF_W-1:0] s2_diff;
  logic [P_W-1:0]           s2_p;

  logic signed [DIFF_W+P_W:0] prod_x;

  logic                     s3_vld;
  logic signed [X_W-1:0]    s3_x;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      exposure_count <= COUNT_W'(1);
      ratio_first    <= RATIO_RESET;
      ratio_second   <= RATIO_RESET;
      ratio_third    <= RATIO_RESET;
      log_offset     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXPOSURE_COUNT: exposure_count <= cfg_data[COUNT_W-1:0];
        REG_RATIO_FIRST:    ratio_first    <= cfg_data[RATIO_W-1:0];
        REG_RATIO_SECOND:   ratio_second   <= cfg_data[RATIO_W-1:0];
        REG_RATIO_THIRD:    ratio_third    <= cfg_data[RATIO_W-1:0];
        REG_LOG_OFFSET:     log_offset     <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  assign en          = !(result_valid && result_stall);
  assign pixel_stall = !en;

  assign samp[0] = pixel.sample_a;
  assign samp[1] = pixel.sample_b;
  assign samp[2] = pixel.sample_c;
  assign samp[3] = pixel.sample_d;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ok[i] = samp[i] < SAT_LEVEL;
    end
    if (exposure_count == '0) begin
      n_eff = COUNT_W'(1);
    end else if (exposure_count > MAX_N) begin
      n_eff = MAX_N;
    end else begin
      n_eff = exposure_count;
    end
    sel_next = '0;
    if (!(n_eff == COUNT_W'(1) || ok[0])) begin
      sel_next = 2'(n_eff - COUNT_W'(1));
      for (int i = 3; i >= 1; i--) begin
        if (COUNT_W'(i) < n_eff && ok[i]) begin
          sel_next = 2'(i);
        end
      end
    end
    diff_next = $signed({1'b0, samp[sel_next]}) - $signed({1'b0, pixel.background});
  end

  assign prod01 = ratio_first * ratio_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= pixel_valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_diff <= diff_next;
      s1_sel  <= sel_next;
      s1_p2   <= prod01[2*RATIO_W-1:16];
    end
  end

  assign prod2 = s1_p2 * ratio_third;

  always_comb begin
    case (s1_sel)
      2'd0:    p_next = UNITY_RATIO;
      2'd1:    p_next = P_W'(ratio_first);
      2'd2:    p_next = P_W'(s1_p2);
      2'd3:    p_next = prod2[P2_W+RATIO_W-1:16];
      default: p_next = UNITY_RATIO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_diff <= s1_diff;
      s2_p    <= p_next;
    end
  end

  assign prod_x = s2_diff * $signed({1'b0, s2_p});

  always_ff @(posedge clk) begin
    if (en) begin
      s3_x <= prod_x[X_W-1:0];
    end
  end

  hdrm_log2 u_log2 (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .x_valid      (s3_vld),
    .x            (s3_x),
    .log_offset   (log_offset),
    .result_valid (result_valid),
    .result       (result)
  );

  a_stall_ties_to_result: assert property (@(posedge clk) disable iff (rst)
    pixel_stall == (result_valid && result_stall))
    else $error("pixel stall does not follow a held result");

  a_lin_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.linear_intensity <= LIN_MAX &&
                      result.linear_intensity >= -LIN_MAX))
    else $error("linear intensity outside saturation range");

  a_code_needs_nonneg: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.log_code != '0) |-> !result.linear_intensity[LIN_W-1])
    else $error("nonzero log code with negative intensity");

endmodule
`default_nettype wire

/* sim/hdr_exposure_pixel_merge_unit_tb.sv */
`default_nettype none
module hdr_exposure_pixel_merge_unit_tb;
  import hdrm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 155;
  localparam logic [SAMPLE_W-1:0] SAT_LEVEL = SAMPLE_W'(PIXEL_LEVELS_DEF - 1);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = 3'd7;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    pixel_t                 px;
    bit                     typed;
    result_t                want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  pixel_t pixel = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int exp_count = 1;
  int ratio_cfg [3] = '{65536, 65536, 65536};
  int log_ofs = 0;

  result_t pending_results [$];
  result_t head_result;
  stim_row_t dir_rows [$];
  int mismatches = 0;
  int cycle_count = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int burst_left = 0;
  bit idle_on = 1'b1;

  hdr_exposure_pixel_merge_unit dut (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel(pixel),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t merge_pixel(pixel_t px);
    longint signed samp [4];
    longint signed bkg, x, lin, code, prod;
    longint unsigned mag, mant;
    int n, e, frac, i;
    bit picked;
    result_t r;
    samp[0] = longint'(px.sample_a);
    samp[1] = longint'(px.sample_b);
    samp[2] = longint'(px.sample_c);
    samp[3] = longint'(px.sample_d);
    bkg = longint'(px.background);
    n = exp_count;
    if (n < 1) n = 1;
    if (n > MAX_EXPOSURES_DEF) n = MAX_EXPOSURES_DEF;
    x = 0;
    if (n == 1 || samp[0] < SAT_LEVEL) begin
      x = (samp[0] - bkg) * 65536;
    end else begin
      prod = longint'(ratio_cfg[0]);
      picked = 1'b0;
      for (i = 1; i < n; i++) begin
        if (!picked) begin
          if (samp[i] < SAT_LEVEL || i == n - 1) begin
            x = (samp[i] - bkg) * prod;
            picked = 1'b1;
          end else begin
            prod = (prod * ratio_cfg[i]) >>> 16;
          end
        end
      end
    end
    lin = x >>> 8;
    if (lin > LIN_MAX) lin = longint'(LIN_MAX);
    if (lin < -LIN_MAX) lin = -longint'(LIN_MAX);
    r.linear_intensity = lin[LIN_W-1:0];
    code = 0;
    if (x > 0) begin
      mag = x;
      e = 0;
      for (i = 0; i < 64; i++)
        if (mag[i]) e = i;
      mant = (e > 30) ? (mag >> (e - 30)) : (mag << (30 - e));
      frac = 0;
      for (i = 0; i < FRAC_BITS; i++) begin
        mant = (mant * mant) >> 30;
        frac = frac << 1;
        if (mant >= 64'h8000_0000) begin
          frac = frac | 1;
          mant = mant >> 1;
        end
      end
      code = longint'(e * 4096 + frac - 16 * 4096 + log_ofs);
      if (code < 0) code = 0;
      if (code > 65535) code = 65535;
    end
    r.log_code = code[CODE_W-1:0];
    return r;
  endfunction

  function automatic pixel_t make_pixel();
    logic [SAMPLE_W-1:0] s [4];
    logic [95:0] raw;
    int lead, i;
    pixel_t px;
    if ($urandom_range(0, 9) == 0) begin
      raw = {$urandom, $urandom, $urandom};
      px = raw[79:0];
    end else begin
      lead = $urandom_range(0, 4);
      for (i = 0; i < 4; i++) begin
        if (i < lead) begin
          s[i] = SAT_LEVEL;
        end else if (i == lead) begin
          case ($urandom_range(0, 3))
            0: s[i] = SAT_LEVEL - 16'd1;
            1: s[i] = 16'($urandom_range(0, 255));
            default: s[i] = 16'($urandom_range(0, 65534));
          endcase
        end else begin
          s[i] = $urandom_range(0, 1) ? SAT_LEVEL : 16'($urandom);
        end
      end
      px.sample_a = s[0];
      px.sample_b = s[1];
      px.sample_c = s[2];
      px.sample_d = s[3];
      px.background = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 1023));
    end
    return px;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_ratio();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 18'd65536;
      2: return 18'($urandom_range(65537, 131071));
      3: return 18'($urandom_range(0, 262143));
      default: return 18'($urandom_range(8192, 65536));
    endcase
  endfunction

  function automatic stim_row_t write_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    r.px = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t pred_row(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                         logic [15:0] d, logic [15:0] bg);
    stim_row_t r;
    r.kind = ROW_PIXEL;
    r.idx = '0;
    r.data = '0;
    r.px = '{a, b, c, d, bg};
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                          logic [15:0] d, logic [15:0] bg,
                                          logic signed [LIN_W-1:0] lin,
                                          logic [CODE_W-1:0] code);
    stim_row_t r;
    r = pred_row(a, b, c, d, bg);
    r.typed = 1'b1;
    r.want.linear_intensity = lin;
    r.want.log_code = code;
    return r;
  endfunction

  task automatic add_row(stim_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_EXPOSURE_COUNT: exp_count = int'(data[2:0]);
      REG_RATIO_FIRST:    ratio_cfg[0] = int'(data[16:0]);
      REG_RATIO_SECOND:   ratio_cfg[1] = int'(data[16:0]);
      REG_RATIO_THIRD:    ratio_cfg[2] = int'(data[16:0]);
      REG_LOG_OFFSET:     log_ofs = int'(data[17:0]);
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(pixel_t px, bit typed, result_t want);
    pixel_valid <= 1'b1;
    pixel <= px;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    pending_results.insert(pending_results.size(), typed ? want : merge_pixel(px));
    if (idle_on && $urandom_range(0, 4) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: lin=%0d code=%0d",
                   result.linear_intensity, result.log_code);
      end else begin
        head_result = pending_results.pop_front();
        if (result.linear_intensity !== head_result.linear_intensity ||
            result.log_code !== head_result.log_code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected lin=%0d code=%0d, got lin=%0d code=%0d",
                     head_result.linear_intensity, head_result.log_code,
                     result.linear_intensity, result.log_code);
        end
      end
    end
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      result_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(0, 12);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  initial begin
    int phase, j;
    logic [CFG_DATA_W-1:0] reg_word;
    add_row(known_row(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 25'sd0, 16'd0));
    add_row(pred_row(16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd0));
    add_row(known_row(16'd0, 16'd0, 16'd0, 16'd0, 16'd65535, -LIN_MAX, 16'd0));
    add_row(known_row(16'd256, 16'd0, 16'd0, 16'd0, 16'd0, 25'sd65536, 16'd32768));
    add_row(known_row(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 25'sd256, 16'd0));
    add_row(pred_row(16'd65534, 16'd12, 16'd345, 16'd6789, 16'd1));
    add_row(write_row(REG_EXPOSURE_COUNT, 18'd4));
    add_row(write_row(REG_RATIO_FIRST, 18'd32768));
    add_row(write_row(REG_RATIO_SECOND, 18'd16384));
    add_row(write_row(REG_RATIO_THIRD, 18'd8192));
    add_row(write_row(REG_LOG_OFFSET, 18'd65536));
    add_row(pred_row(16'd100, 16'd65535, 16'd65535, 16'd65535, 16'd0));
    add_row(pred_row(16'd65535, 16'd1000, 16'd65535, 16'd65535, 16'd10));
    add_row(pred_row(16'd65535, 16'd65535, 16'd2000, 16'd65535, 16'd0));
    add_row(pred_row(16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd0));
    add_row(pred_row(16'd65535, 16'd65535, 16'd65535, 16'd5, 16'd100));
    add_row(write_row(REG_EXPOSURE_COUNT, 18'd0));
    add_row(pred_row(16'd65535, 16'd10, 16'd10, 16'd10, 16'd0));
    add_row(write_row(REG_EXPOSURE_COUNT, 18'd7));
    add_row(pred_row(16'd65535, 16'd65535, 16'd65535, 16'd3000, 16'd0));
    add_row(write_row(REG_RATIO_FIRST, 18'd131071));
    add_row(write_row(REG_RATIO_SECOND, 18'd131071));
    add_row(write_row(REG_RATIO_THIRD, 18'h3FFFF));
    add_row(write_row(REG_LOG_OFFSET, 18'd0));
    add_row(pred_row(16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd0));
    add_row(pred_row(16'd65535, 16'd65534, 16'd0, 16'd0, 16'd0));
    add_row(write_row(REG_RATIO_FIRST, 18'd0));
    add_row(known_row(16'd65535, 16'd500, 16'd0, 16'd0, 16'd0, 25'sd0, 16'd0));
    add_row(write_row(REG_SPARE_FIRST, 18'h3FFFF));
    add_row(write_row(REG_SPARE_LAST, 18'd0));
    add_row(known_row(16'd65535, 16'd500, 16'd0, 16'd0, 16'd0, 25'sd0, 16'd0));
    add_row(write_row(REG_RATIO_FIRST, 18'd65536));
    add_row(write_row(REG_LOG_OFFSET, 18'd262143));
    add_row(known_row(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 25'sd256, 16'd65535));
    add_row(pred_row(16'd65535, 16'd65535, 16'd40000, 16'd0, 16'd0));
    add_row(pred_row(16'd65534, 16'd0, 16'd0, 16'd0, 16'd0));
    add_row(known_row(16'd1, 16'd0, 16'd0, 16'd0, 16'd2, -25'sd256, 16'd0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        pixel_valid <= 1'b0;
        wait_drained();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_on = (phase < RANDOM_PHASES - 2) && (phase % 3 != 2);
      pixel_valid <= 1'b0;
      wait_drained();
      reg_word = 18'($urandom);
      reg_word[2:0] = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                  : 3'($urandom_range(2, 4));
      write_reg(REG_EXPOSURE_COUNT, reg_word);
      write_reg(REG_RATIO_FIRST, pick_ratio());
      write_reg(REG_RATIO_SECOND, pick_ratio());
      write_reg(REG_RATIO_THIRD, pick_ratio());
      case ($urandom_range(0, 5))
        0: reg_word = '0;
        1: reg_word = 18'd262143;
        2: reg_word = 18'($urandom_range(0, 262143));
        default: reg_word = 18'($urandom_range(40000, 90000));
      endcase
      write_reg(REG_LOG_OFFSET, reg_word);
      for (j = 0; j < PHASE_ITEMS; j++) begin
        // hold the result side off while requests keep coming
        if (phase == 1 && j == 30) hold_asked++;
        send_pixel(make_pixel(), 1'b0, '0);
      end
    end

    pixel_valid <= 1'b0;
    wait_drained();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
